>>> design/pcr_pkg.sv
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared constants and controller/datapath interface types for the prime
// counter.
// ----------------------------------------------------------------------------
package pcr_pkg;

    localparam int NUMBER_BITS_DEFAULT = 16;
    localparam int COUNT_BITS          = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // controller -> datapath
    typedef struct packed {
        logic load_range;   // capture range, clear running count
        logic test_init;    // first trial divisor (two)
        logic div_start;    // restart remainder unit on current candidate
        logic div_step;     // one quotient bit
        logic div_next;     // advance trial divisor
        logic cand_next;    // advance candidate
        logic prime_found;  // with cand_next: candidate was prime
        logic out_load;     // copy running count to output register
    } pcr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cand_done;    // candidate reached end of range
        logic cand_small;   // candidate below two
        logic div_last;     // final quotient bit this cycle
        logic div_gt_quo;   // divisor squared exceeds candidate
        logic rem_zero;     // divisor divides candidate
    } pcr_status_t;

endpackage

>>> design/pcr_datapath.sv
// ----------------------------------------------------------------------------
// pcr_datapath
// Candidate/divisor registers, restoring remainder unit and count registers.
// ----------------------------------------------------------------------------
module pcr_datapath
    import pcr_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic [NUMBER_BITS-1:0] range_start,
    input  logic [NUMBER_BITS-1:0] range_end,
    input  pcr_cmd_t               cmd,
    output pcr_status_t            status,
    output logic [COUNT_BITS-1:0]  prime_count
);

    localparam int STEP_BITS = $clog2(NUMBER_BITS);
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(NUMBER_BITS - 1);

    logic [NUMBER_BITS-1:0] cand_reg,    cand_next;
    logic [NUMBER_BITS-1:0] end_reg,     end_next;
    logic [NUMBER_BITS-1:0] divisor_reg, divisor_next;
    logic [NUMBER_BITS-1:0] rem_reg,     rem_next;
    logic [NUMBER_BITS-1:0] quo_reg,     quo_next;
    logic [STEP_BITS-1:0]   step_reg,    step_next;
    logic [COUNT_BITS-1:0]  count_reg,   count_next;
    logic [COUNT_BITS-1:0]  out_reg,     out_next;

    logic [NUMBER_BITS:0]   shifted;
    logic                   fits;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[NUMBER_BITS-1]};
    assign fits    = shifted >= {1'b0, divisor_reg};

    always_comb begin
        cand_next    = cand_reg;
        end_next     = end_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        out_next     = out_reg;

        if (cmd.load_range) begin
            cand_next  = range_start;
            end_next   = range_end;
            count_next = '0;
        end
        if (cmd.test_init) begin
            divisor_next = NUMBER_BITS'(2);
        end
        if (cmd.div_next) begin
            divisor_next = divisor_reg + NUMBER_BITS'(1);
        end
        if (cmd.div_start) begin
            rem_next  = '0;
            quo_next  = cand_reg;
            step_next = '0;
        end
        if (cmd.div_step) begin
            rem_next  = fits ? NUMBER_BITS'(shifted - {1'b0, divisor_reg})
                             : shifted[NUMBER_BITS-1:0];
            quo_next  = {quo_reg[NUMBER_BITS-2:0], fits};
            step_next = step_reg + STEP_BITS'(1);
        end
        if (cmd.cand_next) begin
            cand_next = cand_reg + NUMBER_BITS'(1);
            if (cmd.prime_found && count_reg != COUNT_MAX) begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
        if (cmd.out_load) begin
            out_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg    <= cand_next;
        end_reg     <= end_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        count_reg   <= count_next;
        out_reg     <= out_next;
    end

    // d*d > n exactly when d > floor(n/d)
    assign status.cand_done  = cand_reg >= end_reg;
    assign status.cand_small = cand_reg < NUMBER_BITS'(2);
    assign status.div_last   = step_reg == STEP_LAST;
    assign status.div_gt_quo = divisor_reg > quo_reg;
    assign status.rem_zero   = rem_reg == '0;

    assign prime_count = out_reg;

endmodule

>>> design/pcr_controller.sv
// ----------------------------------------------------------------------------
// pcr_controller
// Sequencer for range walk, trial division and the output handshake.
// ----------------------------------------------------------------------------
module pcr_controller
    import pcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  pcr_status_t status,
    output pcr_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CAND = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_EVAL = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_range = 1'b1;
                    state_next     = ST_CAND;
                end
            end
            ST_CAND: begin
                if (status.cand_done) begin
                    state_next = ST_FIN;
                end else if (status.cand_small) begin
                    cmd.cand_next = 1'b1;
                end else begin
                    cmd.test_init = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (status.div_gt_quo) begin
                    cmd.cand_next   = 1'b1;
                    cmd.prime_found = 1'b1;
                    state_next      = ST_CAND;
                end else if (status.rem_zero) begin
                    cmd.cand_next = 1'b1;
                    state_next    = ST_CAND;
                end else begin
                    cmd.div_next  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_FIN: begin
                if (!valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = valid_reg;

endmodule

>>> design/prime_count_in_range.sv
// ----------------------------------------------------------------------------
// prime_count_in_range
// Counts the primes in [start, end) by trial division with a shared
// restoring remainder unit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_range_start, s_range_end
//  m_      | out       | m_valid / m_ready  | m_prime_count
//
//  Candidates below two are skipped; for each other candidate, trial
//  divisors are tried from two upward. The remainder unit gives one quotient
//  bit per cycle, NB = NUMBER_BITS quotient bits per divisor, then an
//  evaluation step: prime once the divisor exceeds the quotient, composite
//  on a zero remainder. The sequencer returns to idle before the next range.
//  Reset (aresetn low, synchronous) returns the sequencer to idle and
//  empties the output register; datapath registers are not reset.
//  s_ready is high only while idle; a finished count waits in the output
//  register, so a new transaction may be accepted while m_valid is held.
// ----------------------------------------------------------------------------
module prime_count_in_range
    import pcr_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [NUMBER_BITS-1:0] s_range_start,
    input  logic [NUMBER_BITS-1:0] s_range_end,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COUNT_BITS-1:0]  m_prime_count
);

    pcr_cmd_t    cmd;
    pcr_status_t status;

    // sequencer: range walk, divisor loop, output register valid
    pcr_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // registers, remainder unit, count and output data
    pcr_datapath #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_dp (
        .aclk        (aclk),
        .range_start (s_range_start),
        .range_end   (s_range_end),
        .cmd         (cmd),
        .status      (status),
        .prime_count (m_prime_count)
    );

endmodule

>>> design/pcr_checker.sv
// ----------------------------------------------------------------------------
// pcr_checker
// Port-level checks on the prime counter, bound to the top level.
// ----------------------------------------------------------------------------
module pcr_checker
    import pcr_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [NUMBER_BITS-1:0] s_range_start,
    input logic [NUMBER_BITS-1:0] s_range_end,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [COUNT_BITS-1:0]  m_prime_count
);

    logic [1:0] pending_reg, pending_next;
    logic       s_fire, m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg + 2'(s_fire) - 2'(m_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // held result keeps its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prime_count))
        else $error("result changed while stalled");

    // waiting range keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=>
            s_valid && $stable(s_range_start) && $stable(s_range_end))
        else $error("range changed while waiting");

    // one range at a time: busy straight after a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("ready right after accepting a range");

    // no result without a range behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("result without a pending range");

    // at most one in work and one waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 2'd2 |-> m_valid && !s_ready)
        else $error("too many ranges outstanding");

endmodule

bind prime_count_in_range pcr_checker #(
    .NUMBER_BITS (NUMBER_BITS)
) u_pcr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_range_start (s_range_start),
    .s_range_end   (s_range_end),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_prime_count (m_prime_count)
);
